@@ sv/bdc_pkg.sv @@
package bdc_pkg;

   localparam int unsigned TIME_WIDTH  = 32;
   localparam int unsigned COUNT_WIDTH = 4;
   localparam int unsigned CSR_INDEX_WIDTH = 2;

   localparam logic [TIME_WIDTH-1:0] PRESS_SETTLE_RESET   = 32'd272016;
   localparam logic [TIME_WIDTH-1:0] HOLD_POLL_RESET      = 32'd50000;
   localparam logic [TIME_WIDTH-1:0] RELEASE_SETTLE_RESET = 32'd720895;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESS_SETTLE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_POLL      = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELEASE_SETTLE = 2'd2;

   localparam logic [1:0] PHASE_CODE_WAITING  = 2'd0;
   localparam logic [1:0] PHASE_CODE_PRESSED  = 2'd1;
   localparam logic [1:0] PHASE_CODE_HELD     = 2'd2;
   localparam logic [1:0] PHASE_CODE_RELEASED = 2'd3;

   typedef enum logic [3:0] {
      PH_WAITING  = 4'b0001,
      PH_PRESSED  = 4'b0010,
      PH_HELD     = 4'b0100,
      PH_RELEASED = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] time_now;
      logic                  press_event;
      logic                  up_button_level;
      logic                  down_button_level;
   } req_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count_value;
      logic                   count_changed;
      logic                   rearm_buttons;
      logic [1:0]             phase;
   } rsp_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] press_settle_time;
      logic [TIME_WIDTH-1:0] hold_poll_time;
      logic [TIME_WIDTH-1:0] release_settle_time;
   } cfg_type;

   function automatic logic [1:0] phase_code(phase_type ph);
      logic [1:0] code;
      unique case (ph)
         PH_WAITING:  code = PHASE_CODE_WAITING;
         PH_PRESSED:  code = PHASE_CODE_PRESSED;
         PH_HELD:     code = PHASE_CODE_HELD;
         PH_RELEASED: code = PHASE_CODE_RELEASED;
         default:     code = PHASE_CODE_WAITING;
      endcase
      return code;
   endfunction

endpackage

@@ sv/bdc_csr.sv @@
module bdc_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [bdc_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [bdc_pkg::TIME_WIDTH-1:0]         csr_write_data,
   output bdc_pkg::cfg_type                       cfg
);
   import bdc_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_settle_time   <= PRESS_SETTLE_RESET;
         cfg_ff.hold_poll_time      <= HOLD_POLL_RESET;
         cfg_ff.release_settle_time <= RELEASE_SETTLE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PRESS_SETTLE:   cfg_ff.press_settle_time   <= csr_write_data;
            CSR_HOLD_POLL:      cfg_ff.hold_poll_time      <= csr_write_data;
            CSR_RELEASE_SETTLE: cfg_ff.release_settle_time <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/bdc_fsm.sv @@
module bdc_fsm (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  bdc_pkg::req_type  item,
   input  bdc_pkg::cfg_type  cfg,
   output bdc_pkg::rsp_type  result
);
   import bdc_pkg::*;

   phase_type               phase_ff, phase_in;
   logic                    pending_ff, pending_in;
   logic [TIME_WIDTH-1:0]   mark_ff, mark_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;

   logic                    pending_now;
   logic                    up_pressed, down_pressed;
   logic [TIME_WIDTH-1:0]   elapsed, limit;
   logic                    passed;
   logic                    changed, rearm;

   assign pending_now  = pending_ff | item.press_event;
   assign up_pressed   = ~item.up_button_level;
   assign down_pressed = ~item.down_button_level;
   assign elapsed      = item.time_now - mark_ff;

   always_comb begin
      unique case (phase_ff)
         PH_PRESSED: limit = cfg.press_settle_time;
         PH_HELD:    limit = cfg.hold_poll_time;
         default:    limit = cfg.release_settle_time;
      endcase
   end

   assign passed = elapsed > limit;

   always_comb begin
      phase_in   = phase_ff;
      pending_in = pending_now;
      mark_in    = mark_ff;
      count_in   = count_ff;
      changed    = 1'b0;
      rearm      = 1'b0;
      unique case (phase_ff)
         PH_WAITING: begin
            if (pending_now) begin
               phase_in   = PH_PRESSED;
               mark_in    = item.time_now;
               pending_in = 1'b0;
            end
         end
         PH_PRESSED: begin
            if (passed) begin
               // up wins when both are down
               if (up_pressed) begin
                  count_in = count_ff + 1'b1;
               end else if (down_pressed) begin
                  count_in = count_ff - 1'b1;
               end
               changed  = 1'b1;
               phase_in = (up_pressed || down_pressed) ? PH_HELD : PH_RELEASED;
               mark_in  = item.time_now;
            end
         end
         PH_HELD: begin
            if (passed && !up_pressed && !down_pressed) begin
               phase_in = PH_RELEASED;
               mark_in  = item.time_now;
            end
         end
         PH_RELEASED: begin
            // drop any press latched while busy
            if (passed) begin
               phase_in   = PH_WAITING;
               pending_in = 1'b0;
               rearm      = 1'b1;
            end
         end
         default: begin
            phase_in = PH_WAITING;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAITING;
         pending_ff <= 1'b0;
         mark_ff    <= '0;
         count_ff   <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         mark_ff    <= mark_in;
         count_ff   <= count_in;
      end
   end

   assign result.count_value   = count_in;
   assign result.count_changed = changed;
   assign result.rearm_buttons = rearm;
   assign result.phase         = phase_code(phase_in);

endmodule

@@ sv/button_debounce_up_down_counter_unit.sv @@
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    bdc_pkg::req_type (one tick)
// rsp_      out        rsp_valid/rsp_ready    bdc_pkg::rsp_type (one result per tick)
// csr_      in         csr_write_en           csr_index, csr_write_data (write only)
//
// One tick per clock cycle sustained while rsp_ready is high; a result is offered
// after its tick passes the input register, then the result register. The step
// is one 32-bit subtract and compare feeding the phase update between the two.
// Reset is synchronous, active high; no clearing pass is needed.
// A stalled result holds both stages; req_ready falls only when both are full.
module button_debounce_up_down_counter_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bdc_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bdc_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_write_en,
   input  logic [bdc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bdc_pkg::TIME_WIDTH-1:0]      csr_write_data
);
   import bdc_pkg::*;

   logic    in_valid_ff;
   req_type in_item_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_payload_ff;

   logic    advance;
   logic    step_en;
   cfg_type cfg;
   rsp_type step_rsp;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign step_en   = in_valid_ff && advance;

   bdc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   bdc_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
      if (step_en) begin
         rsp_payload_ff <= step_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a tick that is stepped always reaches the result register
   assert property (@(posedge clock) disable iff (reset) step_en |=> rsp_valid_ff)
      else $error("stepped tick did not produce a result");

   // rearm only on the way back to waiting
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.rearm_buttons |-> rsp_payload_ff.phase == PHASE_CODE_WAITING)
      else $error("rearm outside waiting phase");

   // a sample leaves the counter in held or released
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.count_changed |->
         (rsp_payload_ff.phase == PHASE_CODE_HELD || rsp_payload_ff.phase == PHASE_CODE_RELEASED))
      else $error("display refresh with wrong phase");

   // the count moves only on a sampling tick
   assert property (@(posedge clock) disable iff (reset)
      step_en && !step_rsp.count_changed && $past(step_en) && !$past(reset) |->
         step_rsp.count_value == $past(step_rsp.count_value))
      else $error("count changed without a sample");

endmodule
